// ===== hdl/aging_page_replacement_frame_pool_assert.svh =====
// ----------------------------------------------------------------------------
// aging page replacement frame pool: assertion macros
// Shared property shapes, clocked on clk_i and masked while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef AGING_PAGE_REPLACEMENT_FRAME_POOL_ASSERT_SVH
`define AGING_PAGE_REPLACEMENT_FRAME_POOL_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define APR_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// antecedent implies consequent in the next cycle
`define APR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/apr_pkg.sv =====
// ----------------------------------------------------------------------------
// apr_pkg
// Constants and result codes of the aging page replacement frame pool.
// ----------------------------------------------------------------------------
package apr_pkg;

  // default geometry
  localparam int unsigned DefProcesses       = 8;
  localparam int unsigned DefPagesPerProcess = 2048;
  localparam int unsigned DefUserFrameCount  = 12288;
  localparam int unsigned DefElementsPerPage = 1024;

  // fixed field widths
  localparam int unsigned FrameW = 14;
  localparam int unsigned HistW  = 16;

  // page table entry bits
  localparam int unsigned ValidBit = 15;
  localparam int unsigned RefBit   = 14;
  localparam logic [HistW-1:0] FullHistory = 16'hFFFF;

  // register reset values
  localparam logic [13:0] ThresholdReset = 14'd1000;
  localparam logic [6:0]  EssentialReset = 7'd10;

  // register indexes
  localparam logic CfgThreshold = 1'b0;
  localparam logic CfgEssential = 1'b1;

  // commands
  localparam logic [1:0] CmdAccess  = 2'd0;
  localparam logic [1:0] CmdAge     = 2'd1;
  localparam logic [1:0] CmdRelease = 2'd2;
  localparam logic [1:0] CmdLoad    = 2'd3;

  // result status codes
  localparam logic [3:0] StHit       = 4'd0;
  localparam logic [3:0] StFault     = 4'd1;
  localparam logic [3:0] StReplaced  = 4'd2;
  localparam logic [3:0] StAged      = 4'd3;
  localparam logic [3:0] StReleased  = 4'd4;
  localparam logic [3:0] StLoaded    = 4'd5;
  localparam logic [3:0] StNoVictim  = 4'd6;
  localparam logic [3:0] StNoFrames  = 4'd7;
  localparam logic [3:0] StOutOfRng  = 4'd8;

  // replacement attempts
  localparam logic [2:0] AttNone = 3'd0;
  localparam logic [2:0] AttSame = 3'd1;
  localparam logic [2:0] AttFree = 3'd2;
  localparam logic [2:0] AttOwn  = 3'd3;
  localparam logic [2:0] AttRand = 3'd4;

endpackage

// ===== hdl/aging_page_replacement_frame_pool.sv =====
// ----------------------------------------------------------------------------
// aging_page_replacement_frame_pool
// Page tables, aging histories and a shared free-frame list, one command
// at a time, held in synchronous memories.
// ----------------------------------------------------------------------------
// Usage:
//  - Commands enter on the in channel (valid/ready); one result leaves on the
//    out channel (valid/ready) for every command.
//  - Settings are written through cfg_we_i / cfg_idx_i / cfg_data_i while idle.
//  - After reset a clearing pass sweeps the page table and free list, one
//    entry a cycle, over max(PROCESSES*PAGES_PER_PROCESS, USER_FRAME_COUNT)
//    entries (16384 by default); in_ready_o stays low until it ends.
//  - A replacement scans the histories of the non-essential pages, then up to
//    three passes over the free list at one entry a cycle, then a remainder
//    step over the 16 bits of the random value.
//  - One memory read port per store sets that pace: one entry per cycle.
//  - The result sits in an output register; a stalled receiver holds it and
//    the next command is still taken, stopping only before its own result.
// ----------------------------------------------------------------------------
module aging_page_replacement_frame_pool #(
  parameter int unsigned PROCESSES         = apr_pkg::DefProcesses,
  parameter int unsigned PAGES_PER_PROCESS = apr_pkg::DefPagesPerProcess,
  parameter int unsigned USER_FRAME_COUNT  = apr_pkg::DefUserFrameCount,
  parameter int unsigned ELEMENTS_PER_PAGE = apr_pkg::DefElementsPerPage
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [13:0] cfg_data_i,
  // command channel
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  command_i,
  input  logic [2:0]  process_id_i,
  input  logic [20:0] element_index_i,
  input  logic [15:0] random_value_i,
  // result channel
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [3:0]  status_o,
  output logic [13:0] frame_number_o,
  output logic [2:0]  attempt_o,
  output logic [10:0] victim_page_o,
  output logic [13:0] free_count_out_o
);

  `include "aging_page_replacement_frame_pool_assert.svh"

  localparam int unsigned PeDepth  = PROCESSES * PAGES_PER_PROCESS;
  localparam int unsigned PeAw     = $clog2(PeDepth);
  localparam int unsigned PgW      = $clog2(PAGES_PER_PROCESS);
  localparam int unsigned OwW      = (PROCESSES > 1) ? $clog2(PROCESSES) : 1;
  localparam int unsigned FcW      = $clog2(USER_FRAME_COUNT + 1);
  localparam int unsigned FlAw     = $clog2(USER_FRAME_COUNT);
  localparam int unsigned FrW      = apr_pkg::FrameW;
  localparam int unsigned FlW      = 1 + OwW + PgW + FrW;
  localparam int unsigned IxMax    = (PAGES_PER_PROCESS > USER_FRAME_COUNT) ?
                                     PAGES_PER_PROCESS : USER_FRAME_COUNT;
  localparam int unsigned IxW      = $clog2(IxMax + 1);
  localparam int unsigned EssW     = $clog2(PAGES_PER_PROCESS + 1);
  localparam int unsigned EppSh    = $clog2(ELEMENTS_PER_PAGE);
  localparam int unsigned PgfW     = 22;
  localparam int unsigned ClrDepth = (PeDepth > USER_FRAME_COUNT) ? PeDepth : USER_FRAME_COUNT;
  localparam int unsigned ClrW     = $clog2(ClrDepth);
  localparam int unsigned HW       = apr_pkg::HistW;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_ACC_CHK, S_ACC_TAKE, S_SCAN, S_VICT, S_FL_SCAN, S_MOD,
    S_A4_RD, S_A4_GET, S_TAKE_RD, S_TAKE_WR, S_PUSH, S_AGE, S_REL,
    S_LC_RD, S_LC_CHK, S_LD_RD, S_LD_CHK, S_LD_WR, S_FINISH
  } state_e;

  // memories
  logic [HW-1:0]  pe_mem [PeDepth];
  logic [HW-1:0]  ph_mem [PeDepth];
  logic [FlW-1:0] fl_mem [USER_FRAME_COUNT];

  logic [HW-1:0]  pe_rdata_q, ph_rdata_q;
  logic [FlW-1:0] fl_rdata_q;

  logic            pe_we, ph_we, fl_we;
  logic [PeAw-1:0] pe_waddr, ph_waddr, pt_raddr;
  logic [HW-1:0]   pe_wdata, ph_wdata;
  logic [FlAw-1:0] fl_waddr, fl_raddr;
  logic [FlW-1:0]  fl_wdata;

  // control registers
  state_e          state_q, state_d;
  logic [ClrW-1:0] clr_q, clr_d;
  logic [1:0]      cmd_q, cmd_d;
  logic [2:0]      pid_q, pid_d;
  logic [PgW-1:0]  page_q, page_d;
  logic [15:0]     rnd_q, rnd_d;
  logic [FcW-1:0]  fc_q, fc_d;
  logic [13:0]     thr_q, thr_d;
  logic [6:0]      ess_q, ess_d;
  logic [IxW-1:0]  idx_q, idx_d, chk_idx_q, chk_idx_d;
  logic            chk_v_q, chk_v_d;
  logic            found_q, found_d;
  logic [HW-1:0]   minh_q, minh_d;
  logic [PgW-1:0]  victim_q, victim_d;
  logic [14:0]     ventry_q, ventry_d;
  logic [FlAw-1:0] take_idx_q, take_idx_d;
  logic [FrW-1:0]  sframe_q, sframe_d;
  logic [1:0]      pass_q, pass_d;
  logic [FcW-1:0]  rem_q, rem_d;
  logic [3:0]      divcnt_q, divcnt_d;
  logic [EssW-1:0] need_q, need_d;
  logic [3:0]      res_status_q, res_status_d;
  logic [FrW-1:0]  res_frame_q, res_frame_d;
  logic [2:0]      res_att_q, res_att_d;
  logic            out_valid_q, out_valid_d;
  logic [3:0]      out_status_q, out_status_d;
  logic [13:0]     out_frame_q, out_frame_d;
  logic [2:0]      out_att_q, out_att_d;
  logic [10:0]     out_victim_q, out_victim_d;
  logic [13:0]     out_fc_q, out_fc_d;

  // derived values
  logic [EssW-1:0] ess_eff;
  logic [PgfW-1:0] pg_full;
  logic [PeAw-1:0] base_in, base_q, slot_in, slot_q;
  logic [FcW-1:0]  fc_m1;
  logic            in_xfer;

  assign ess_eff = (32'(ess_q) > PAGES_PER_PROCESS) ? EssW'(PAGES_PER_PROCESS) : EssW'(ess_q);
  assign pg_full = PgfW'(ess_eff) + PgfW'(element_index_i >> EppSh);
  assign base_in = PeAw'(32'(process_id_i) * PAGES_PER_PROCESS);
  assign base_q  = PeAw'(32'(pid_q) * PAGES_PER_PROCESS);
  assign slot_in = base_in + PeAw'(pg_full[PgW-1:0]);
  assign slot_q  = base_q + PeAw'(page_q);
  assign fc_m1   = fc_q - 1'b1;
  assign in_ready_o = (state_q == S_IDLE);
  assign in_xfer = in_valid_i && in_ready_o;

  // page table and history memories
  always_ff @(posedge clk_i) begin
    if (pe_we) pe_mem[pe_waddr] <= pe_wdata;
    if (ph_we) ph_mem[ph_waddr] <= ph_wdata;
    pe_rdata_q <= pe_mem[pt_raddr];
    ph_rdata_q <= ph_mem[pt_raddr];
  end

  // free list memory
  always_ff @(posedge clk_i) begin
    if (fl_we) fl_mem[fl_waddr] <= fl_wdata;
    fl_rdata_q <= fl_mem[fl_raddr];
  end

  // sequencer next state and memory controls
  always_comb begin
    logic [HW-1:0]  e;
    logic [HW-1:0]  h;
    logic [FlW-1:0] r;
    logic           r_tag;
    logic           r_own;
    logic           r_pg;
    logic           hit;
    logic [FcW:0]   sh;

    state_d = state_q;       clr_d = clr_q;         cmd_d = cmd_q;
    pid_d = pid_q;           page_d = page_q;       rnd_d = rnd_q;
    fc_d = fc_q;             thr_d = thr_q;         ess_d = ess_q;
    idx_d = idx_q;           chk_idx_d = chk_idx_q; chk_v_d = chk_v_q;
    found_d = found_q;       minh_d = minh_q;       victim_d = victim_q;
    ventry_d = ventry_q;     take_idx_d = take_idx_q;
    sframe_d = sframe_q;     pass_d = pass_q;       rem_d = rem_q;
    divcnt_d = divcnt_q;     need_d = need_q;
    res_status_d = res_status_q; res_frame_d = res_frame_q; res_att_d = res_att_q;
    out_status_d = out_status_q; out_frame_d = out_frame_q; out_att_d = out_att_q;
    out_victim_d = out_victim_q; out_fc_d = out_fc_q;
    out_valid_d = out_valid_q && !out_ready_i;

    pe_we = 1'b0; pe_waddr = slot_q; pe_wdata = '0;
    ph_we = 1'b0; ph_waddr = slot_q; ph_wdata = apr_pkg::FullHistory;
    fl_we = 1'b0; fl_waddr = fc_q[FlAw-1:0]; fl_wdata = '0;
    pt_raddr = base_q + PeAw'(idx_q[PgW-1:0]);
    fl_raddr = idx_q[FlAw-1:0];

    e = pe_rdata_q;
    h = ph_rdata_q;
    r = fl_rdata_q;
    r_tag = r[FlW-1];
    r_own = (r[FrW+PgW +: OwW] == OwW'(pid_q));
    r_pg  = (r[FrW +: PgW] == page_q);
    hit = 1'b0;
    sh = '0;

    // register writes
    if (cfg_we_i) begin
      if (cfg_idx_i == apr_pkg::CfgThreshold) thr_d = cfg_data_i;
      else ess_d = cfg_data_i[6:0];
    end

    unique case (state_q)
      // sweep both stores to their reset contents
      S_CLEAR: begin
        pe_waddr = PeAw'(clr_q);
        pe_we = (32'(clr_q) < PeDepth);
        fl_waddr = FlAw'(clr_q);
        fl_wdata = FlW'(FrW'(clr_q));
        fl_we = (32'(clr_q) < USER_FRAME_COUNT);
        clr_d = clr_q + 1'b1;
        if (32'(clr_q) == ClrDepth - 1) state_d = S_IDLE;
      end
      S_IDLE: begin
        pt_raddr = slot_in;
        if (in_xfer) begin
          cmd_d = command_i;
          pid_d = process_id_i;
          page_d = pg_full[PgW-1:0];
          rnd_d = random_value_i;
          res_frame_d = '0;
          res_att_d = apr_pkg::AttNone;
          victim_d = '0;
          idx_d = '0;
          chk_v_d = 1'b0;
          need_d = '0;
          if (32'(process_id_i) >= PROCESSES) begin
            res_status_d = apr_pkg::StOutOfRng;
            state_d = S_FINISH;
          end else begin
            unique case (command_i)
              apr_pkg::CmdAccess: begin
                if (32'(pg_full) >= PAGES_PER_PROCESS) begin
                  res_status_d = apr_pkg::StOutOfRng;
                  state_d = S_FINISH;
                end else begin
                  state_d = S_ACC_CHK;
                end
              end
              apr_pkg::CmdAge:     state_d = S_AGE;
              apr_pkg::CmdRelease: state_d = S_REL;
              apr_pkg::CmdLoad:    state_d = S_LC_RD;
              default:             state_d = S_IDLE;
            endcase
          end
        end
      end
      // hit, direct fault or start of the victim scan
      S_ACC_CHK: begin
        fl_raddr = fc_m1[FlAw-1:0];
        if (e[apr_pkg::ValidBit]) begin
          pe_we = 1'b1;
          pe_wdata = e | (HW'(1) << apr_pkg::RefBit);
          res_status_d = apr_pkg::StHit;
          res_frame_d = e[FrW-1:0];
          state_d = S_FINISH;
        end else if (fc_q > FcW'(thr_q)) begin
          state_d = S_ACC_TAKE;
        end else begin
          idx_d = IxW'(ess_eff);
          found_d = 1'b0;
          state_d = S_SCAN;
        end
      end
      S_ACC_TAKE: begin
        fc_d = fc_m1;
        pe_we = 1'b1;
        pe_wdata = {2'b11, r[FrW-1:0]};
        ph_we = 1'b1;
        res_status_d = apr_pkg::StFault;
        res_frame_d = r[FrW-1:0];
        state_d = S_FINISH;
      end
      // least history among valid non-essential pages, one per cycle
      S_SCAN: begin
        if (chk_v_q && e[apr_pkg::ValidBit] && (!found_q || h < minh_q)) begin
          found_d = 1'b1;
          minh_d = h;
          victim_d = chk_idx_q[PgW-1:0];
          ventry_d = e[14:0];
        end
        if (32'(idx_q) < PAGES_PER_PROCESS) begin
          chk_v_d = 1'b1;
          chk_idx_d = idx_q;
          idx_d = idx_q + 1'b1;
        end else begin
          chk_v_d = 1'b0;
          if (!chk_v_q) state_d = S_VICT;
        end
      end
      S_VICT: begin
        if (!found_q) begin
          res_status_d = apr_pkg::StNoVictim;
          victim_d = '0;
          state_d = S_FINISH;
        end else if (fc_q == '0) begin
          res_status_d = apr_pkg::StNoFrames;
          victim_d = '0;
          state_d = S_FINISH;
        end else begin
          pe_we = 1'b1;
          pe_waddr = base_q + PeAw'(victim_q);
          pe_wdata = {1'b0, ventry_q};
          pass_d = 2'd1;
          idx_d = '0;
          chk_v_d = 1'b0;
          state_d = S_FL_SCAN;
        end
      end
      // free-list search, one pass per attempt
      S_FL_SCAN: begin
        case (pass_q)
          2'd1:    hit = r_tag && r_own && r_pg;
          2'd2:    hit = !r_tag;
          default: hit = r_tag && r_own && !r_pg;
        endcase
        if (chk_v_q && hit) begin
          take_idx_d = chk_idx_q[FlAw-1:0];
          sframe_d = r[FrW-1:0];
          res_att_d = 3'(pass_q);
          chk_v_d = 1'b0;
          state_d = S_TAKE_RD;
        end else if (idx_q < IxW'(fc_q)) begin
          chk_v_d = 1'b1;
          chk_idx_d = idx_q;
          idx_d = idx_q + 1'b1;
        end else begin
          chk_v_d = 1'b0;
          if (!chk_v_q) begin
            idx_d = '0;
            if (pass_q == 2'd3) begin
              rem_d = '0;
              divcnt_d = '0;
              state_d = S_MOD;
            end else begin
              pass_d = pass_q + 1'b1;
            end
          end
        end
      end
      // random value modulo free count, one bit a cycle
      S_MOD: begin
        sh = {rem_q, rnd_q[15]};
        if (sh >= (FcW+1)'(fc_q)) sh = sh - (FcW+1)'(fc_q);
        rem_d = sh[FcW-1:0];
        rnd_d = rnd_q << 1;
        divcnt_d = divcnt_q + 1'b1;
        if (divcnt_q == 4'd15) state_d = S_A4_RD;
      end
      S_A4_RD: begin
        fl_raddr = rem_q[FlAw-1:0];
        take_idx_d = rem_q[FlAw-1:0];
        state_d = S_A4_GET;
      end
      S_A4_GET: begin
        sframe_d = r[FrW-1:0];
        res_att_d = apr_pkg::AttRand;
        state_d = S_TAKE_RD;
      end
      // move the tail entry into the taken slot
      S_TAKE_RD: begin
        fl_raddr = fc_m1[FlAw-1:0];
        state_d = S_TAKE_WR;
      end
      S_TAKE_WR: begin
        fl_we = 1'b1;
        fl_waddr = take_idx_q;
        fl_wdata = r;
        fc_d = fc_m1;
        state_d = S_PUSH;
      end
      // return the victim frame, map the new page
      S_PUSH: begin
        if (32'(fc_q) < USER_FRAME_COUNT) begin
          fl_we = 1'b1;
          fl_wdata = {1'b1, OwW'(pid_q), victim_q, ventry_q[FrW-1:0]};
          fc_d = fc_q + 1'b1;
        end
        pe_we = 1'b1;
        pe_wdata = {2'b11, sframe_q};
        ph_we = 1'b1;
        res_status_d = apr_pkg::StReplaced;
        res_frame_d = sframe_q;
        state_d = S_FINISH;
      end
      // aging sweep
      S_AGE: begin
        if (chk_v_q && e[apr_pkg::ValidBit]) begin
          pe_we = 1'b1;
          pe_waddr = base_q + PeAw'(chk_idx_q[PgW-1:0]);
          pe_wdata = e & ~(HW'(1) << apr_pkg::RefBit);
          ph_we = 1'b1;
          ph_waddr = pe_waddr;
          ph_wdata = {e[apr_pkg::RefBit], h[HW-1:1]};
        end
        if (32'(idx_q) < PAGES_PER_PROCESS) begin
          chk_v_d = 1'b1;
          chk_idx_d = idx_q;
          idx_d = idx_q + 1'b1;
        end else begin
          chk_v_d = 1'b0;
          if (!chk_v_q) begin
            res_status_d = apr_pkg::StAged;
            state_d = S_FINISH;
          end
        end
      end
      // release sweep
      S_REL: begin
        if (chk_v_q && e[apr_pkg::ValidBit]) begin
          pe_we = 1'b1;
          pe_waddr = base_q + PeAw'(chk_idx_q[PgW-1:0]);
          pe_wdata = e & ~(HW'(1) << apr_pkg::ValidBit);
          if (32'(fc_q) < USER_FRAME_COUNT) begin
            fl_we = 1'b1;
            fl_wdata = FlW'(e[FrW-1:0]);
            fc_d = fc_q + 1'b1;
          end
        end
        if (32'(idx_q) < PAGES_PER_PROCESS) begin
          chk_v_d = 1'b1;
          chk_idx_d = idx_q;
          idx_d = idx_q + 1'b1;
        end else begin
          chk_v_d = 1'b0;
          if (!chk_v_q) begin
            res_status_d = apr_pkg::StReleased;
            state_d = S_FINISH;
          end
        end
      end
      // count essential pages that need a frame
      S_LC_RD: begin
        if (idx_q < IxW'(ess_eff)) begin
          state_d = S_LC_CHK;
        end else if (FcW'(need_q) > fc_q) begin
          res_status_d = apr_pkg::StNoFrames;
          state_d = S_FINISH;
        end else begin
          idx_d = '0;
          state_d = S_LD_RD;
        end
      end
      S_LC_CHK: begin
        if (!e[apr_pkg::ValidBit]) need_d = need_q + 1'b1;
        idx_d = idx_q + 1'b1;
        state_d = S_LC_RD;
      end
      // install essential pages from the list tail
      S_LD_RD: begin
        if (idx_q < IxW'(ess_eff)) begin
          state_d = S_LD_CHK;
        end else begin
          res_status_d = apr_pkg::StLoaded;
          state_d = S_FINISH;
        end
      end
      S_LD_CHK: begin
        fl_raddr = fc_m1[FlAw-1:0];
        if (!e[apr_pkg::ValidBit]) begin
          state_d = S_LD_WR;
        end else begin
          idx_d = idx_q + 1'b1;
          state_d = S_LD_RD;
        end
      end
      S_LD_WR: begin
        pe_we = 1'b1;
        pe_waddr = base_q + PeAw'(idx_q[PgW-1:0]);
        pe_wdata = {2'b10, r[FrW-1:0]};
        ph_we = 1'b1;
        ph_waddr = pe_waddr;
        fc_d = fc_m1;
        idx_d = idx_q + 1'b1;
        state_d = S_LD_RD;
      end
      // hand the result to the output register
      S_FINISH: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_status_d = res_status_q;
          out_frame_d = res_frame_q;
          out_att_d = res_att_q;
          out_victim_d = 11'(victim_q);
          out_fc_d = 14'(fc_q);
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      clr_q <= '0;
      fc_q <= FcW'(USER_FRAME_COUNT);
      thr_q <= apr_pkg::ThresholdReset;
      ess_q <= apr_pkg::EssentialReset;
      chk_v_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q <= clr_d;
      fc_q <= fc_d;
      thr_q <= thr_d;
      ess_q <= ess_d;
      chk_v_q <= chk_v_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;           pid_q <= pid_d;           page_q <= page_d;
    rnd_q <= rnd_d;           idx_q <= idx_d;           chk_idx_q <= chk_idx_d;
    found_q <= found_d;       minh_q <= minh_d;         victim_q <= victim_d;
    ventry_q <= ventry_d;     take_idx_q <= take_idx_d; sframe_q <= sframe_d;
    pass_q <= pass_d;         rem_q <= rem_d;           divcnt_q <= divcnt_d;
    need_q <= need_d;         res_status_q <= res_status_d;
    res_frame_q <= res_frame_d; res_att_q <= res_att_d;
    out_status_q <= out_status_d; out_frame_q <= out_frame_d;
    out_att_q <= out_att_d;   out_victim_q <= out_victim_d; out_fc_q <= out_fc_d;
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = out_status_q;
  assign frame_number_o   = out_frame_q;
  assign attempt_o        = out_att_q;
  assign victim_page_o    = out_victim_q;
  assign free_count_out_o = out_fc_q;

  // checks
  `APR_ASSERT_SAME(a_fc_bound, 1'b1, 32'(fc_q) <= USER_FRAME_COUNT,
    "free count above pool size")
  `APR_ASSERT_SAME(a_rem_bound, state_q == S_A4_RD, rem_q < fc_q,
    "random pick outside free list")
  `APR_ASSERT_SAME(a_att_only_replace,
    out_valid_o && status_o != apr_pkg::StReplaced, attempt_o == apr_pkg::AttNone,
    "attempt set on a non-replacement result")
  `APR_ASSERT_NEXT(a_take_shrinks, state_q == S_TAKE_WR, fc_q == $past(fc_q) - 1'b1,
    "take did not shrink the free list")

endmodule

// ===== verif/tb.sv =====
// ----------------------------------------------------------------------------
// aging page replacement frame pool testbench
// Drives commands with random bursts and gaps, stalls the result channel,
// and checks every result against a cycle-free model of page tables, aging
// histories and the free-frame list.
// ----------------------------------------------------------------------------
module tb;
  import apr_pkg::*;

  localparam int unsigned NPROC  = DefProcesses;
  localparam int unsigned NPAGE  = DefPagesPerProcess;
  localparam int unsigned NFRAME = DefUserFrameCount;
  localparam int unsigned EPP    = DefElementsPerPage;
  localparam int unsigned IDLE_LIMIT = 200000;

  typedef struct packed {
    logic [3:0]  status;
    logic [13:0] frame;
    logic [2:0]  attempt;
    logic [10:0] victim;
    logic [13:0] free_cnt;
  } pool_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic        cfg_idx_i = CfgThreshold;
  logic [13:0] cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [1:0]  command_i = CmdAccess;
  logic [2:0]  process_id_i = '0;
  logic [20:0] element_index_i = '0;
  logic [15:0] random_value_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [3:0]  status_o;
  logic [13:0] frame_number_o;
  logic [2:0]  attempt_o;
  logic [10:0] victim_page_o;
  logic [13:0] free_count_out_o;

  aging_page_replacement_frame_pool dut (.*);

  always #6 clk_i = ~clk_i;

  // model state
  logic [15:0] pte [NPROC*NPAGE];
  logic [15:0] hist [NPROC*NPAGE];
  logic [13:0] pool_frame [NFRAME];
  bit          pool_tag [NFRAME];
  logic [2:0]  pool_owner [NFRAME];
  logic [10:0] pool_page [NFRAME];
  int unsigned pool_len;
  int unsigned threshold_reg;
  int unsigned essential_reg;

  pool_result_t pending_q[$];
  int errors = 0;
  int status_seen [9];
  int hold_cycles = 0;
  int idle_count = 0;

  // remove entry i, last entry fills the hole
  task automatic pool_take(input int unsigned i, output logic [13:0] fr);
    fr = pool_frame[i];
    pool_frame[i] = pool_frame[pool_len-1];
    pool_tag[i]   = pool_tag[pool_len-1];
    pool_owner[i] = pool_owner[pool_len-1];
    pool_page[i]  = pool_page[pool_len-1];
    pool_len--;
  endtask

  task automatic pool_push(input logic [13:0] fr, input bit tg, input logic [2:0] own,
                           input logic [10:0] pg);
    if (pool_len < NFRAME) begin
      pool_frame[pool_len] = fr;
      pool_tag[pool_len]   = tg;
      pool_owner[pool_len] = own;
      pool_page[pool_len]  = pg;
      pool_len++;
    end
  endtask

  // work out the result of one accepted command
  task automatic predict_command(input logic [1:0] cmd, input logic [2:0] pid,
                                 input logic [20:0] elem, input logic [15:0] rnd);
    pool_result_t r;
    int unsigned ess, base, page, slot, vic, need, i;
    logic [15:0] minh;
    logic [13:0] fr, vfr;
    bit found;
    r = '0;
    r.status = StOutOfRng;
    ess = (essential_reg > NPAGE) ? NPAGE : essential_reg;
    base = pid * NPAGE;
    if (pid < NPROC) begin
      case (cmd)
        CmdAccess: begin
          page = ess + elem / EPP;
          if (page < NPAGE) begin
            slot = base + page;
            if (pte[slot][ValidBit]) begin
              pte[slot][RefBit] = 1'b1;
              r.status = StHit;
              r.frame = pte[slot][13:0];
            end else if (pool_len > threshold_reg) begin
              pool_take(pool_len - 1, fr);
              pte[slot] = {2'b11, fr};
              hist[slot] = FullHistory;
              r.status = StFault;
              r.frame = fr;
            end else begin
              found = 0;
              minh = '0;
              vic = 0;
              for (i = ess; i < NPAGE; i++)
                if (pte[base+i][ValidBit] && (!found || hist[base+i] < minh)) begin
                  found = 1;
                  minh = hist[base+i];
                  vic = i;
                end
              if (!found) r.status = StNoVictim;
              else if (pool_len == 0) r.status = StNoFrames;
              else begin
                vfr = pte[base+vic][13:0];
                pte[base+vic][ValidBit] = 1'b0;
                for (i = 0; i < pool_len && r.attempt == AttNone; i++)
                  if (pool_tag[i] && pool_owner[i] == pid && pool_page[i] == page) begin
                    pool_take(i, fr);
                    r.attempt = AttSame;
                  end
                for (i = 0; i < pool_len && r.attempt == AttNone; i++)
                  if (!pool_tag[i]) begin
                    pool_take(i, fr);
                    r.attempt = AttFree;
                  end
                for (i = 0; i < pool_len && r.attempt == AttNone; i++)
                  if (pool_tag[i] && pool_owner[i] == pid && pool_page[i] != page) begin
                    pool_take(i, fr);
                    r.attempt = AttOwn;
                  end
                if (r.attempt == AttNone) begin
                  pool_take(rnd % pool_len, fr);
                  r.attempt = AttRand;
                end
                pool_push(vfr, 1, pid, vic[10:0]);
                pte[slot] = {2'b11, fr};
                hist[slot] = FullHistory;
                r.status = StReplaced;
                r.frame = fr;
                r.victim = vic[10:0];
              end
            end
          end
        end
        CmdAge: begin
          for (i = 0; i < NPAGE; i++)
            if (pte[base+i][ValidBit]) begin
              hist[base+i] = {pte[base+i][RefBit], hist[base+i][15:1]};
              pte[base+i][RefBit] = 1'b0;
            end
          r.status = StAged;
        end
        CmdRelease: begin
          for (i = 0; i < NPAGE; i++)
            if (pte[base+i][ValidBit]) begin
              pool_push(pte[base+i][13:0], 0, '0, '0);
              pte[base+i][ValidBit] = 1'b0;
            end
          r.status = StReleased;
        end
        default: begin
          need = 0;
          for (i = 0; i < ess; i++)
            if (!pte[base+i][ValidBit]) need++;
          if (need > pool_len) r.status = StNoFrames;
          else begin
            for (i = 0; i < ess; i++)
              if (!pte[base+i][ValidBit]) begin
                pool_take(pool_len - 1, fr);
                pte[base+i] = {2'b10, fr};
                hist[base+i] = FullHistory;
              end
            r.status = StLoaded;
          end
        end
      endcase
    end
    r.free_cnt = pool_len[13:0];
    pending_q.push_back(r);
  endtask

  // command transfers feed the model
  always @(posedge clk_i)
    if (rst_ni && in_valid_i && in_ready_o)
      predict_command(command_i, process_id_i, element_index_i, random_value_i);

  // result transfers checked against the oldest expectation
  always @(posedge clk_i)
    if (rst_ni && out_valid_o && out_ready_i) begin
      pool_result_t want;
      if (pending_q.size() == 0) begin
        $error("result with nothing expected: status %0d", status_o);
        errors++;
      end else begin
        want = pending_q.pop_front();
        if (status_o != want.status) begin
          $error("status: expected %0d, got %0d", want.status, status_o); errors++;
        end
        if (frame_number_o != want.frame) begin
          $error("frame_number: expected %0d, got %0d", want.frame, frame_number_o);
          errors++;
        end
        if (attempt_o != want.attempt) begin
          $error("attempt: expected %0d, got %0d", want.attempt, attempt_o); errors++;
        end
        if (victim_page_o != want.victim) begin
          $error("victim_page: expected %0d, got %0d", want.victim, victim_page_o);
          errors++;
        end
        if (free_count_out_o != want.free_cnt) begin
          $error("free_count_out: expected %0d, got %0d", want.free_cnt, free_count_out_o);
          errors++;
        end
        if (want.status <= StOutOfRng) status_seen[want.status]++;
      end
    end

  // receiver: stall stretches, free-running stretches, and long hold-offs
  int stall_left = 0;
  bit stall_mode = 0;
  always @(negedge clk_i) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_ready_i <= 1'b0;
    end else begin
      if (stall_left == 0) begin
        stall_mode = ~stall_mode;
        stall_left = $urandom_range(5, 60);
      end else stall_left--;
      out_ready_i <= stall_mode ? ($urandom_range(0, 2) == 0) : 1'b1;
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_count <= 0;
    else idle_count <= idle_count + 1;
    if (idle_count >= IDLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // sender bursts
  int burst_left = 0;

  task automatic send_cmd(input logic [1:0] cmd, input logic [2:0] pid,
                          input logic [20:0] elem, input logic [15:0] rnd);
    int gap;
    @(negedge clk_i);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 8);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 30);
      if (gap > 0) begin
        in_valid_i = 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    burst_left--;
    in_valid_i = 1'b1;
    command_i = cmd;
    process_id_i = pid;
    element_index_i = elem;
    random_value_i = rnd;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic wait_idle();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic idx, input int unsigned value);
    wait_idle();
    @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_data_i = value[13:0];
    @(posedge clk_i);
    if (idx == CfgThreshold) threshold_reg = value & 14'h3FFF;
    else essential_reg = value & 7'h7F;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  // random access on a small page window so hits and re-faults recur
  task automatic random_mix(input int count, input int pids);
    int k, sel;
    logic [20:0] el;
    for (k = 0; k < count; k++) begin
      sel = $urandom_range(0, 99);
      el = $urandom_range(0, 11) * EPP + $urandom_range(0, EPP - 1);
      if (sel < 70) send_cmd(CmdAccess, $urandom_range(0, pids - 1), el, $urandom);
      else if (sel < 80) send_cmd(CmdAge, $urandom_range(0, pids - 1), $urandom, $urandom);
      else if (sel < 85) send_cmd(CmdLoad, $urandom_range(0, pids - 1), $urandom, $urandom);
      else if (sel < 90) send_cmd(CmdRelease, $urandom_range(0, 7), $urandom, $urandom);
      else send_cmd(CmdAccess, $urandom_range(0, 7), $urandom, $urandom);
    end
  endtask

  // directed: every command, range limits, direct faults and hits
  task automatic test_directed();
    send_cmd(CmdLoad, 3'd0, '0, '0);
    send_cmd(CmdAccess, 3'd0, '0, 16'hFFFF);
    send_cmd(CmdAccess, 3'd0, 21'd1023, '0);
    send_cmd(CmdAccess, 3'd0, 21'd2086911, '0);
    send_cmd(CmdAccess, 3'd7, 21'h1FFFFF, 16'hFFFF);
    send_cmd(CmdAccess, 3'd7, 21'd2048 * 0 + 21'd38 * 1024, '0);
    send_cmd(CmdAge, 3'd0, 21'h1FFFFF, 16'hFFFF);
    send_cmd(CmdAge, 3'd0, '0, '0);
    send_cmd(CmdLoad, 3'd0, '0, '0);
    send_cmd(CmdRelease, 3'd0, '0, '0);
    send_cmd(CmdRelease, 3'd5, '0, '0);
    send_cmd(CmdAccess, 3'd0, 21'd5000, '0);
  endtask

  // replacement: no victim, evictions, same-page refill, tiny essential set
  task automatic test_replacement();
    write_reg(CfgEssential, 1);
    write_reg(CfgThreshold, 12288);
    send_cmd(CmdAccess, 3'd2, 21'd100, '0);
    write_reg(CfgThreshold, 0);
    send_cmd(CmdAccess, 3'd2, 21'd0, '0);
    send_cmd(CmdAccess, 3'd2, 21'd1024, '0);
    send_cmd(CmdAge, 3'd2, '0, '0);
    send_cmd(CmdAccess, 3'd2, 21'd1024, '0);
    write_reg(CfgThreshold, 12288);
    send_cmd(CmdAccess, 3'd2, 21'd2048, '0);
    send_cmd(CmdAccess, 3'd2, 21'd0, 16'h1234);
    send_cmd(CmdAccess, 3'd2, 21'd2047 * 1024, '0);
  endtask

  // receiver holds off while cheap commands keep coming, then a full drain
  task automatic test_backpressure();
    int k;
    wait_idle();
    hold_cycles = 400;
    for (k = 0; k < 10; k++)
      send_cmd(k[0] ? CmdAge : CmdAccess, 3'd2, 21'd0, $urandom);
    wait_idle();
  endtask

  task automatic test_random();
    write_reg(CfgThreshold, 12200);
    random_mix(40, 4);
    write_reg(CfgThreshold, 0);
    write_reg(CfgEssential, 64);
    random_mix(35, 8);
    write_reg(CfgEssential, 5);
    write_reg(CfgThreshold, 12288);
    random_mix(25, 3);
  endtask

  initial begin
    int unsigned i;
    for (i = 0; i < NPROC * NPAGE; i++) begin
      pte[i] = '0;
      hist[i] = '0;
    end
    for (i = 0; i < NFRAME; i++) begin
      pool_frame[i] = i[13:0];
      pool_tag[i] = 0;
      pool_owner[i] = '0;
      pool_page[i] = '0;
    end
    pool_len = NFRAME;
    threshold_reg = ThresholdReset;
    essential_reg = EssentialReset;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed();
    test_replacement();
    test_backpressure();
    test_random();
    wait_idle();
    repeat (50) @(posedge clk_i);

    $display("covered: %0d hits, %0d direct faults, %0d replacements, %0d aged",
             status_seen[StHit], status_seen[StFault], status_seen[StReplaced],
             status_seen[StAged]);
    $display("  %0d released, %0d loaded, %0d no victim, %0d no frames, %0d out of range",
             status_seen[StReleased], status_seen[StLoaded], status_seen[StNoVictim],
             status_seen[StNoFrames], status_seen[StOutOfRng]);
    if (errors == 0 && pending_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/apr_pkg.sv
hdl/aging_page_replacement_frame_pool.sv
verif/tb.sv
